[hdl/nsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// Types and constants shared by the sentence checker front end, queue and
// back end.
// ----------------------------------------------------------------------------
package nsc_pkg;

   localparam int TALKER_LEN   = 2;
   localparam int SENTENCE_LEN = 3;
   localparam int PROP_MIN_LEN = 3;
   localparam int TOKEN_MAX    = 15;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

   localparam int MC_WIDTH     = 7;
   localparam int FIELD_WIDTH  = 6;
   localparam logic [MC_WIDTH-1:0] MC_RESET = 7'd16;

   localparam logic [7:0] CHAR_NL     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_P      = 8'h50;

   localparam logic [2:0] ADDR_MAX_CHANNELS = 3'd0;

   typedef enum logic [2:0] {
      ST_MATCH    = 3'd0,
      ST_NO_CSUM  = 3'd1,
      ST_BAD_CSUM = 3'd2,
      ST_BAD_ID   = 3'd3,
      ST_NO_DOLLAR = 3'd4,
      ST_BLANK    = 3'd5
   } status_type;

   typedef enum logic [5:0] {
      PH_START    = 6'b000001,
      PH_ADDR     = 6'b000010,
      PH_DATA     = 6'b000100,
      PH_HEX      = 6'b001000,
      PH_NODOLLAR = 6'b010000,
      PH_BADID    = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       nl;
      logic       dollar;
      logic       star;
      logic       comma;
      logic       p_char;
      logic       hex_ok;
      logic [3:0] nibble;
   } item_type;

endpackage

[hdl/nmea_sentence_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_checker
// NMEA 0183 sentence checker: validates the leading dollar sign and address
// token, computes and compares the checksum and counts data fields.
// ----------------------------------------------------------------------------
// The checker takes one byte per clock cycle while the queue is not full. Each
// byte is classified on entry and placed in a four-word queue; the back end
// consumes one word per cycle unless stalled and holds the result of a line in
// an output register until it is popped. The back end only stalls on a line
// feed while the previous result is still unread, so the queue absorbs short
// stalls on the result side. Carriage returns are discarded at the input.
// max_channels is at address 0 and should be written only while the checker
// is idle.
// ----------------------------------------------------------------------------
module nmea_sentence_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [7:0]                      req_char_in,
   output logic                            empty,
   input  logic                            pop,
   output logic [2:0]                      rsp_status,
   output logic                            rsp_proprietary,
   output logic [15:0]                     rsp_talker_id,
   output logic [23:0]                     rsp_ident_code,
   output logic [nsc_pkg::FIELD_WIDTH-1:0] rsp_field_count,
   output logic [7:0]                      rsp_computed_checksum,
   output logic [7:0]                      rsp_received_checksum,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [2:0]                      paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   logic [nsc_pkg::MC_WIDTH-1:0] max_channels_ff, max_channels_in;
   nsc_pkg::item_type            front_item;
   logic                         front_keep;
   logic                         q_full;
   logic                         q_valid;
   nsc_pkg::item_type            q_item;
   logic                         q_take;
   logic                         out_valid;
   logic                         csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      max_channels_in = max_channels_ff;
      if (csr_write && paddr == nsc_pkg::ADDR_MAX_CHANNELS) begin
         max_channels_in = pwdata[nsc_pkg::MC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_channels_ff <= nsc_pkg::MC_RESET;
      end else begin
         max_channels_ff <= max_channels_in;
      end
   end

   assign prdata = (paddr == nsc_pkg::ADDR_MAX_CHANNELS)
                   ? {{(32 - nsc_pkg::MC_WIDTH){1'b0}}, max_channels_ff} : '0;

   nsc_front u_front (
      .char_in (req_char_in),
      .item    (front_item),
      .keep    (front_keep)
   );

   nsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push && front_keep),
      .wr_data  (front_item),
      .full     (q_full),
      .rd_en    (q_take),
      .rd_valid (q_valid),
      .rd_data  (q_item)
   );

   assign full = q_full;

   nsc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .max_channels          (max_channels_ff),
      .item_valid            (q_valid),
      .item                  (q_item),
      .item_take             (q_take),
      .out_valid             (out_valid),
      .out_pop               (pop),
      .out_status            (rsp_status),
      .out_proprietary       (rsp_proprietary),
      .out_talker_id         (rsp_talker_id),
      .out_ident_code        (rsp_ident_code),
      .out_field_count       (rsp_field_count),
      .out_computed_checksum (rsp_computed_checksum),
      .out_received_checksum (rsp_received_checksum)
   );

   assign empty = !out_valid;

endmodule

[hdl/nsc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_front
// Classifies each incoming byte: line end, delimiters, proprietary marker and
// hex digit value. Carriage returns are flagged for dropping.
// ----------------------------------------------------------------------------
module nsc_front (
   input  logic [7:0]       char_in,
   output nsc_pkg::item_type item,
   output logic             keep
);

   logic is_dec;
   logic is_upper;
   logic is_lower;
   logic [7:0] dec_val;
   logic [7:0] upper_val;
   logic [7:0] lower_val;

   assign is_dec    = (char_in >= 8'h30) && (char_in <= 8'h39);
   assign is_upper  = (char_in >= 8'h41) && (char_in <= 8'h46);
   assign is_lower  = (char_in >= 8'h61) && (char_in <= 8'h66);
   assign dec_val   = char_in - 8'h30;
   assign upper_val = char_in - 8'h37;
   assign lower_val = char_in - 8'h57;

   always_comb begin
      item.ch     = char_in;
      item.nl     = (char_in == nsc_pkg::CHAR_NL);
      item.dollar = (char_in == nsc_pkg::CHAR_DOLLAR);
      item.star   = (char_in == nsc_pkg::CHAR_STAR);
      item.comma  = (char_in == nsc_pkg::CHAR_COMMA);
      item.p_char = (char_in == nsc_pkg::CHAR_P);
      item.hex_ok = is_dec || is_upper || is_lower;
      if (is_dec) begin
         item.nibble = dec_val[3:0];
      end else if (is_upper) begin
         item.nibble = upper_val[3:0];
      end else begin
         item.nibble = lower_val[3:0];
      end
   end

   assign keep = (char_in != nsc_pkg::CHAR_CR);

endmodule

[hdl/nsc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_queue
// Short first-in first-out queue of classified words between the front end
// and the back end.
// ----------------------------------------------------------------------------
module nsc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  nsc_pkg::item_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output nsc_pkg::item_type rd_data
);

   nsc_pkg::item_type               mem_ff [nsc_pkg::QUEUE_DEPTH];
   logic [nsc_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [nsc_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [nsc_pkg::QUEUE_CW-1:0]    count_ff, count_in;
   logic                            do_wr;
   logic                            do_rd;

   assign full     = (count_ff == nsc_pkg::QUEUE_CW'(nsc_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nsc_pkg::QUEUE_CW'(nsc_pkg::QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");

   a_pointer_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0 && count_ff != nsc_pkg::QUEUE_CW'(nsc_pkg::QUEUE_DEPTH))
      |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("Queue pointers meet while the queue is partly filled.");

endmodule

[hdl/nsc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_back
// Sentence state machine: tracks the address token, checksum and fields,
// and holds the finished result of each line until it is taken.
// ----------------------------------------------------------------------------
module nsc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nsc_pkg::MC_WIDTH-1:0]    max_channels,
   input  logic                            item_valid,
   input  nsc_pkg::item_type               item,
   output logic                            item_take,
   output logic                            out_valid,
   input  logic                            out_pop,
   output logic [2:0]                      out_status,
   output logic                            out_proprietary,
   output logic [15:0]                     out_talker_id,
   output logic [23:0]                     out_ident_code,
   output logic [nsc_pkg::FIELD_WIDTH-1:0] out_field_count,
   output logic [7:0]                      out_computed_checksum,
   output logic [7:0]                      out_received_checksum
);

   nsc_pkg::phase_type               phase_ff, phase_in;
   logic [7:0]                       xor_ff, xor_in;
   logic [3:0]                       tlen_ff, tlen_in;
   logic [15:0]                      talker_ff, talker_in;
   logic [23:0]                      ident_ff, ident_in;
   logic                             prop_ff, prop_in;
   logic [nsc_pkg::FIELD_WIDTH-1:0]  fields_ff, fields_in;
   logic                             nonempty_ff, nonempty_in;
   logic [7:0]                       hexv_ff, hexv_in;
   logic [1:0]                       hexd_ff, hexd_in;
   logic                             hexbad_ff, hexbad_in;

   logic                             ovalid_ff, ovalid_in;
   nsc_pkg::status_type              ostatus_ff, ostatus_in;
   logic                             oprop_ff, oprop_in;
   logic [15:0]                      otalker_ff, otalker_in;
   logic [23:0]                      oident_ff, oident_in;
   logic [nsc_pkg::FIELD_WIDTH-1:0]  ofields_ff, ofields_in;
   logic [7:0]                       oxor_ff, oxor_in;
   logic [7:0]                       ohex_ff, ohex_in;

   logic [nsc_pkg::MC_WIDTH-1:0]     lim_wide;
   logic [nsc_pkg::FIELD_WIDTH-1:0]  limit;
   logic [nsc_pkg::FIELD_WIDTH-1:0]  closed_fields;
   logic                             addr_ok;
   logic                             line_end;
   nsc_pkg::status_type              status;

   assign lim_wide = (max_channels >= 7'd2) ? max_channels - 7'd2 : '0;
   assign limit    = (lim_wide > 7'd63) ? 6'd63 : lim_wide[nsc_pkg::FIELD_WIDTH-1:0];

   assign closed_fields = (nonempty_ff && (fields_ff < limit)) ? fields_ff + 1'b1
                                                                : fields_ff;

   assign addr_ok = prop_ff ? (tlen_ff >= 4'(nsc_pkg::PROP_MIN_LEN))
                            : (tlen_ff >= 4'(nsc_pkg::TALKER_LEN + nsc_pkg::SENTENCE_LEN));

   assign item_take = item_valid && (!item.nl || !ovalid_ff || out_pop);
   assign line_end  = item_take && item.nl;

   always_comb begin
      unique case (phase_ff)
         nsc_pkg::PH_START:    status = nsc_pkg::ST_BLANK;
         nsc_pkg::PH_NODOLLAR: status = nsc_pkg::ST_NO_DOLLAR;
         nsc_pkg::PH_BADID:    status = nsc_pkg::ST_BAD_ID;
         nsc_pkg::PH_ADDR:     status = addr_ok ? nsc_pkg::ST_NO_CSUM : nsc_pkg::ST_BAD_ID;
         nsc_pkg::PH_DATA:     status = nsc_pkg::ST_NO_CSUM;
         nsc_pkg::PH_HEX: begin
            status = (!hexbad_ff && hexd_ff == 2'd2 && hexv_ff == xor_ff)
                     ? nsc_pkg::ST_MATCH : nsc_pkg::ST_BAD_CSUM;
         end
         default:              status = nsc_pkg::ST_NO_DOLLAR;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      xor_in      = xor_ff;
      tlen_in     = tlen_ff;
      talker_in   = talker_ff;
      ident_in    = ident_ff;
      prop_in     = prop_ff;
      fields_in   = fields_ff;
      nonempty_in = nonempty_ff;
      hexv_in     = hexv_ff;
      hexd_in     = hexd_ff;
      hexbad_in   = hexbad_ff;

      if (line_end) begin
         phase_in    = nsc_pkg::PH_START;
         xor_in      = '0;
         tlen_in     = '0;
         talker_in   = '0;
         ident_in    = '0;
         prop_in     = 1'b0;
         fields_in   = '0;
         nonempty_in = 1'b0;
         hexv_in     = '0;
         hexd_in     = '0;
         hexbad_in   = 1'b0;
      end else if (item_take) begin
         unique case (phase_ff)
            nsc_pkg::PH_START: begin
               phase_in = item.dollar ? nsc_pkg::PH_ADDR : nsc_pkg::PH_NODOLLAR;
            end
            nsc_pkg::PH_ADDR: begin
               if (item.star) begin
                  phase_in = addr_ok ? nsc_pkg::PH_HEX : nsc_pkg::PH_BADID;
               end else begin
                  xor_in = xor_ff ^ item.ch;
                  if (item.comma) begin
                     phase_in    = addr_ok ? nsc_pkg::PH_DATA : nsc_pkg::PH_BADID;
                     nonempty_in = 1'b0;
                  end else begin
                     if (tlen_ff == '0 && item.p_char) begin
                        prop_in = 1'b1;
                     end else if (prop_ff) begin
                        if (tlen_ff >= 4'd1 && tlen_ff <= 4'd3) begin
                           ident_in = {ident_ff[15:0], item.ch};
                        end
                     end else if (tlen_ff < 4'(nsc_pkg::TALKER_LEN)) begin
                        talker_in = {talker_ff[7:0], item.ch};
                     end else if (tlen_ff <
                                  4'(nsc_pkg::TALKER_LEN + nsc_pkg::SENTENCE_LEN)) begin
                        ident_in = {ident_ff[15:0], item.ch};
                     end
                     if (tlen_ff < 4'(nsc_pkg::TOKEN_MAX)) begin
                        tlen_in = tlen_ff + 1'b1;
                     end
                  end
               end
            end
            nsc_pkg::PH_DATA: begin
               if (item.star) begin
                  fields_in   = closed_fields;
                  nonempty_in = 1'b0;
                  phase_in    = nsc_pkg::PH_HEX;
               end else begin
                  xor_in = xor_ff ^ item.ch;
                  if (item.comma) begin
                     fields_in   = closed_fields;
                     nonempty_in = 1'b0;
                  end else begin
                     nonempty_in = 1'b1;
                  end
               end
            end
            nsc_pkg::PH_HEX: begin
               if (hexd_ff < 2'd2) begin
                  if (!item.hex_ok) begin
                     hexbad_in = 1'b1;
                  end else if (!hexbad_ff) begin
                     hexv_in = {hexv_ff[3:0], item.nibble};
                  end
                  hexd_in = hexd_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ovalid_in  = (ovalid_ff && !out_pop) || line_end;
      ostatus_in = ostatus_ff;
      oprop_in   = oprop_ff;
      otalker_in = otalker_ff;
      oident_in  = oident_ff;
      ofields_in = ofields_ff;
      oxor_in    = oxor_ff;
      ohex_in    = ohex_ff;
      if (line_end) begin
         ostatus_in = status;
         if (status == nsc_pkg::ST_MATCH || status == nsc_pkg::ST_NO_CSUM ||
             status == nsc_pkg::ST_BAD_CSUM) begin
            oprop_in   = prop_ff;
            otalker_in = talker_ff;
            oident_in  = ident_ff;
            ofields_in = (phase_ff == nsc_pkg::PH_DATA) ? closed_fields : fields_ff;
            oxor_in    = xor_ff;
            ohex_in    = hexv_ff;
         end else begin
            oprop_in   = 1'b0;
            otalker_in = '0;
            oident_in  = '0;
            ofields_in = '0;
            oxor_in    = '0;
            ohex_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= nsc_pkg::PH_START;
         xor_ff      <= '0;
         tlen_ff     <= '0;
         talker_ff   <= '0;
         ident_ff    <= '0;
         prop_ff     <= 1'b0;
         fields_ff   <= '0;
         nonempty_ff <= 1'b0;
         hexv_ff     <= '0;
         hexd_ff     <= '0;
         hexbad_ff   <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         xor_ff      <= xor_in;
         tlen_ff     <= tlen_in;
         talker_ff   <= talker_in;
         ident_ff    <= ident_in;
         prop_ff     <= prop_in;
         fields_ff   <= fields_in;
         nonempty_ff <= nonempty_in;
         hexv_ff     <= hexv_in;
         hexd_ff     <= hexd_in;
         hexbad_ff   <= hexbad_in;
         ovalid_ff   <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      ostatus_ff <= ostatus_in;
      oprop_ff   <= oprop_in;
      otalker_ff <= otalker_in;
      oident_ff  <= oident_in;
      ofields_ff <= ofields_in;
      oxor_ff    <= oxor_in;
      ohex_ff    <= ohex_in;
   end

   assign out_valid             = ovalid_ff;
   assign out_status            = ostatus_ff;
   assign out_proprietary       = oprop_ff;
   assign out_talker_id         = otalker_ff;
   assign out_ident_code        = oident_ff;
   assign out_field_count       = ofields_ff;
   assign out_computed_checksum = oxor_ff;
   assign out_received_checksum = ohex_ff;

   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && (ostatus_ff == nsc_pkg::ST_BAD_ID ||
                     ostatus_ff == nsc_pkg::ST_NO_DOLLAR ||
                     ostatus_ff == nsc_pkg::ST_BLANK))
      |-> (!oprop_ff && otalker_ff == '0 && oident_ff == '0 && ofields_ff == '0 &&
           oxor_ff == '0 && ohex_ff == '0))
      else $error("Error status carries a non-zero payload.");

   a_prop_no_talker: assert property (@(posedge clock) disable iff (reset)
      prop_ff |-> (talker_ff == '0))
      else $error("Proprietary sentence has collected talker characters.");

endmodule
